@@ design/stc_pkg.sv @@
// ----------------------------------------------------------------------------
// stc_pkg: shared types and constants of the source code tokenizer
// Token codes, lexer modes, keyword table, byte classes and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package stc_pkg;

	localparam int MAX_TOKEN_LEN_DEF = 32;
	localparam int NUM_KW = 10;
	localparam int KW_MAX_LEN = 6;

	// token codes
	localparam logic [5:0] TOK_IDENTIFIER   = 6'd0;
	localparam logic [5:0] TOK_STRING       = 6'd6;
	localparam logic [5:0] TOK_INT_DATA     = 6'd7;
	localparam logic [5:0] TOK_FLOAT_DATA   = 6'd8;
	localparam logic [5:0] TOK_LPAREN       = 6'd9;
	localparam logic [5:0] TOK_RPAREN       = 6'd10;
	localparam logic [5:0] TOK_LCBRACKET    = 6'd11;
	localparam logic [5:0] TOK_RCBRACKET    = 6'd12;
	localparam logic [5:0] TOK_LHBRACKET    = 6'd13;
	localparam logic [5:0] TOK_RHBRACKET    = 6'd14;
	localparam logic [5:0] TOK_SEMICOLON    = 6'd15;
	localparam logic [5:0] TOK_COLON        = 6'd16;
	localparam logic [5:0] TOK_EQUALS       = 6'd17;
	localparam logic [5:0] TOK_DOUBLEEQUALS = 6'd18;
	localparam logic [5:0] TOK_COMMENT      = 6'd19;
	localparam logic [5:0] TOK_COMMA        = 6'd20;
	localparam logic [5:0] TOK_PERIOD       = 6'd21;
	localparam logic [5:0] TOK_PLUS         = 6'd22;
	localparam logic [5:0] TOK_MINUS        = 6'd23;
	localparam logic [5:0] TOK_MULTIPLY     = 6'd24;
	localparam logic [5:0] TOK_DIVIDE       = 6'd25;
	localparam logic [5:0] TOK_GTHAN        = 6'd28;
	localparam logic [5:0] TOK_LTHAN        = 6'd29;
	localparam logic [5:0] TOK_ERROR        = 6'd33;

	// error codes
	localparam logic [1:0] ERR_NONE        = 2'd0;
	localparam logic [1:0] ERR_DECIMAL     = 2'd1;
	localparam logic [1:0] ERR_UNTERM_STR  = 2'd2;

	// characters
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_DIGIT_0 = 8'd48;
	localparam logic [7:0] CH_DIGIT_9 = 8'd57;

	// keyword table
	localparam logic [47:0] KW_WORD [NUM_KW] = '{
		"if", "else", "int", "float", "struct",
		"return", "void", "true", "false", "bool"
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{
		3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd6, 3'd4, 3'd4, 3'd5, 3'd4
	};
	localparam logic [5:0] KW_CODE [NUM_KW] = '{
		6'd1, 6'd2, 6'd3, 6'd5, 6'd4, 6'd26, 6'd27, 6'd31, 6'd32, 6'd30
	};

	typedef enum logic [2:0] {
		M_IDLE    = 3'd0,
		M_IDENT   = 3'd1,
		M_NUMBER  = 3'd2,
		M_SLASH   = 3'd3,
		M_COMMENT = 3'd4,
		M_EQUAL   = 3'd5,
		M_STRING  = 3'd6,
		M_SKIP    = 3'd7
	} mode_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       mode_wr;
		mode_t      mode_val;
		logic       clear;
		logic       append;
		logic       set_dec;
		logic       idx_clr;
		logic       idx_inc;
		logic       emit;
		logic [5:0] emit_code;
		logic       emit_byte;
		logic       emit_last;
		logic       emit_trunc;
		logic [1:0] emit_err;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		mode_t      mode;
		logic [7:0] c;
		logic       eos;
		logic       dec;
		logic       ovf;
		logic       len_zero;
		logic       last_byte;
		logic       kw_hit;
		logic [5:0] kw_code;
		logic       out_free;
	} status_t;

	// keyword byte at position pos, zero past its length
	function automatic logic [7:0] kw_char(input int k, input int pos);
		int len;
		begin
			len = int'(KW_LEN[k]);
			if (pos < len) begin
				kw_char = KW_WORD[k][(len - 1 - pos) * 8 +: 8];
			end else begin
				kw_char = 8'd0;
			end
		end
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		is_alpha = ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
	endfunction

	// single-character punctuation: bit 6 flags a hit
	function automatic logic [6:0] punct(input logic [7:0] c);
		case (c)
			8'h2B:   punct = {1'b1, TOK_PLUS};
			8'h2D:   punct = {1'b1, TOK_MINUS};
			8'h2A:   punct = {1'b1, TOK_MULTIPLY};
			8'h2C:   punct = {1'b1, TOK_COMMA};
			8'h2E:   punct = {1'b1, TOK_PERIOD};
			8'h28:   punct = {1'b1, TOK_LPAREN};
			8'h29:   punct = {1'b1, TOK_RPAREN};
			8'h7B:   punct = {1'b1, TOK_LCBRACKET};
			8'h7D:   punct = {1'b1, TOK_RCBRACKET};
			8'h3E:   punct = {1'b1, TOK_GTHAN};
			8'h3C:   punct = {1'b1, TOK_LTHAN};
			8'h5B:   punct = {1'b1, TOK_LHBRACKET};
			8'h5D:   punct = {1'b1, TOK_RHBRACKET};
			8'h3A:   punct = {1'b1, TOK_COLON};
			8'h3B:   punct = {1'b1, TOK_SEMICOLON};
			default: punct = 7'd0;
		endcase
	endfunction

endpackage

@@ design/stc_src_if.sv @@
// ----------------------------------------------------------------------------
// stc_src_if: source byte channel
// One source byte with its end-of-source mark per transaction.
// ----------------------------------------------------------------------------
interface stc_src_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_of_source;

	modport source(output valid, char_byte, end_of_source, input ready);
	modport sink(input valid, char_byte, end_of_source, output ready);
endinterface

@@ design/stc_tok_if.sv @@
// ----------------------------------------------------------------------------
// stc_tok_if: token result channel
// One token result (code, optional content byte, flags) per transaction.
// ----------------------------------------------------------------------------
interface stc_tok_if;
	logic       valid;
	logic       ready;
	logic [5:0] token_code;
	logic [7:0] content_byte;
	logic       byte_valid;
	logic       last_of_token;
	logic       truncated;
	logic [1:0] error_code;

	modport source(output valid, token_code, content_byte, byte_valid, last_of_token,
		truncated, error_code, input ready);
	modport sink(input valid, token_code, content_byte, byte_valid, last_of_token,
		truncated, error_code, output ready);
endinterface

@@ design/stc_datapath.sv @@
// ----------------------------------------------------------------------------
// stc_datapath: tokenizer storage and output register
// Holds the lexer mode, content buffer, length, flags, keyword match
// vector, the current source byte and the registered result.
// ----------------------------------------------------------------------------
module stc_datapath #(
	parameter int MAX_TOKEN_LEN = stc_pkg::MAX_TOKEN_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  stc_pkg::cmd_t      cmd,
	output stc_pkg::status_t   st,
	input  logic [7:0]         char_byte,
	input  logic               end_of_source,
	input  logic               tok_ready,
	output logic               tok_valid,
	output logic [5:0]         token_code,
	output logic [7:0]         content_byte,
	output logic               byte_valid,
	output logic               last_of_token,
	output logic               truncated,
	output logic [1:0]         error_code
);

	localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
	localparam int IDX_W = $clog2(MAX_TOKEN_LEN);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);

	stc_pkg::mode_t               mode_q;
	logic [7:0]                   buf_q [MAX_TOKEN_LEN];
	logic [LEN_W-1:0]             len_q;
	logic                         dec_q;
	logic                         ovf_q;
	logic [stc_pkg::NUM_KW-1:0]   kw_q;
	logic [7:0]                   c_q;
	logic                         eos_q;
	logic [IDX_W-1:0]             idx_q;

	logic                         out_valid_q;
	logic [5:0]                   code_q;
	logic [7:0]                   byte_q;
	logic                         bvalid_q;
	logic                         last_q;
	logic                         trunc_q;
	logic [1:0]                   err_q;

	logic [LEN_W-1:0]             len_eff;
	logic [stc_pkg::NUM_KW-1:0]   kw_eff;
	logic [stc_pkg::NUM_KW-1:0]   kw_next;
	logic                         kw_hit;
	logic [5:0]                   kw_code;
	logic [LEN_W-1:0]             idx_next;

	// length and match vector as seen after an optional clear
	assign len_eff = cmd.clear ? '0 : len_q;
	assign kw_eff  = cmd.clear ? '1 : kw_q;
	assign idx_next = LEN_W'(idx_q) + LEN_W'(1);

	// narrow keyword candidates with the appended byte
	always_comb begin
		for (int k = 0; k < stc_pkg::NUM_KW; k++) begin
			kw_next[k] = kw_eff[k] && (len_eff < LEN_W'(stc_pkg::KW_LEN[k]))
				&& (c_q == stc_pkg::kw_char(k, int'(len_eff)));
		end
	end

	// pick the keyword whose length matches the content
	always_comb begin
		kw_hit  = 1'b0;
		kw_code = stc_pkg::TOK_IDENTIFIER;
		for (int k = 0; k < stc_pkg::NUM_KW; k++) begin
			if (kw_q[k] && (len_q == LEN_W'(stc_pkg::KW_LEN[k])) && !ovf_q) begin
				kw_hit  = 1'b1;
				kw_code = stc_pkg::KW_CODE[k];
			end
		end
	end

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stc_pkg::M_IDLE;
			len_q  <= '0;
			dec_q  <= 1'b0;
			ovf_q  <= 1'b0;
			kw_q   <= '1;
			idx_q  <= '0;
		end else begin
			if (cmd.mode_wr) begin
				mode_q <= cmd.mode_val;
			end
			if (cmd.append) begin
				if (len_eff < LEN_MAX) begin
					len_q <= len_eff + LEN_W'(1);
					kw_q  <= kw_next;
					ovf_q <= cmd.clear ? 1'b0 : ovf_q;
				end else begin
					len_q <= len_eff;
					kw_q  <= kw_eff;
					ovf_q <= 1'b1;
				end
			end else if (cmd.clear) begin
				len_q <= '0;
				kw_q  <= '1;
				ovf_q <= 1'b0;
			end
			if (cmd.set_dec) begin
				dec_q <= 1'b1;
			end else if (cmd.clear) begin
				dec_q <= 1'b0;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_next[IDX_W-1:0];
			end
		end
	end

	// content buffer and latched input byte
	always_ff @(posedge clk) begin
		if (cmd.append && (len_eff < LEN_MAX)) begin
			buf_q[len_eff[IDX_W-1:0]] <= c_q;
		end
		if (cmd.load) begin
			c_q   <= char_byte;
			eos_q <= end_of_source;
		end
	end

	// result register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (tok_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			code_q   <= cmd.emit_code;
			byte_q   <= cmd.emit_byte ? buf_q[idx_q] : 8'd0;
			bvalid_q <= cmd.emit_byte;
			last_q   <= cmd.emit_last;
			trunc_q  <= cmd.emit_trunc;
			err_q    <= cmd.emit_err;
		end
	end

	assign st.mode      = mode_q;
	assign st.c         = c_q;
	assign st.eos       = eos_q;
	assign st.dec       = dec_q;
	assign st.ovf       = ovf_q;
	assign st.len_zero  = (len_q == '0);
	assign st.last_byte = (idx_next == len_q);
	assign st.kw_hit    = kw_hit;
	assign st.kw_code   = kw_code;
	assign st.out_free  = !out_valid_q || tok_ready;

	assign tok_valid     = out_valid_q;
	assign token_code    = code_q;
	assign content_byte  = byte_q;
	assign byte_valid    = bvalid_q;
	assign last_of_token = last_q;
	assign truncated     = trunc_q;
	assign error_code    = err_q;

endmodule

@@ design/stc_controller.sv @@
// ----------------------------------------------------------------------------
// stc_controller: tokenizer sequencer
// Steps one source byte through decode, token emission, start of a new
// token and end-of-source flush, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module stc_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  stc_pkg::status_t  st,
	output stc_pkg::cmd_t     cmd
);

	typedef enum logic [4:0] {
		ST_WAIT   = 5'b00001,
		ST_DECODE = 5'b00010,
		ST_START  = 5'b00100,
		ST_FINAL  = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	typedef enum logic [1:0] {
		AFT_START   = 2'd0,
		AFT_CLRIDLE = 2'd1,
		AFT_DONE    = 2'd2
	} after_t;

	state_t     state_q, state_d;
	after_t     after_q, after_d;
	logic [5:0] tok_q, tok_d;
	logic       ident_q, ident_d;

	logic       dig, let_c;
	logic [6:0] pc;
	logic [5:0] num_code;
	logic       finish;

	assign dig      = stc_pkg::is_digit(st.c);
	assign let_c    = stc_pkg::is_alpha(st.c);
	assign pc       = stc_pkg::punct(st.c);
	assign num_code = st.dec ? stc_pkg::TOK_FLOAT_DATA : stc_pkg::TOK_INT_DATA;
	assign in_ready = (state_q == ST_WAIT);

	always_comb begin
		state_d = state_q;
		after_d = after_q;
		tok_d   = tok_q;
		ident_d = ident_q;
		cmd     = '0;
		finish  = 1'b0;
		cmd.mode_val = stc_pkg::M_IDLE;
		cmd.idx_clr  = (state_q != ST_EMIT);
		case (state_q)
			// take the next source byte
			ST_WAIT: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			// handle the byte against the open token
			ST_DECODE: begin
				case (st.mode)
					stc_pkg::M_IDENT: begin
						if (dig || let_c) begin
							cmd.append = 1'b1;
							state_d    = ST_FINAL;
						end else begin
							tok_d = stc_pkg::TOK_IDENTIFIER; ident_d = 1'b1;
							after_d = AFT_START; state_d = ST_EMIT;
						end
					end
					stc_pkg::M_NUMBER: begin
						if (dig) begin
							cmd.append = 1'b1;
							state_d    = ST_FINAL;
						end else if (st.c == stc_pkg::CH_DOT) begin
							if (!st.dec) begin
								cmd.set_dec = 1'b1;
								cmd.append  = 1'b1;
								state_d     = ST_FINAL;
							end else if (st.out_free) begin
								cmd.emit = 1'b1; cmd.emit_code = stc_pkg::TOK_ERROR;
								cmd.emit_last = 1'b1; cmd.emit_err = stc_pkg::ERR_DECIMAL;
								cmd.clear = 1'b1; cmd.mode_wr = 1'b1;
								cmd.mode_val = stc_pkg::M_SKIP;
								state_d = ST_FINAL;
							end
						end else begin
							tok_d = num_code; ident_d = 1'b0;
							after_d = AFT_START; state_d = ST_EMIT;
						end
					end
					stc_pkg::M_SLASH: begin
						if (st.c == stc_pkg::CH_SLASH) begin
							cmd.clear = 1'b1; cmd.mode_wr = 1'b1;
							cmd.mode_val = stc_pkg::M_COMMENT;
							state_d = ST_FINAL;
						end else if (st.out_free) begin
							cmd.emit = 1'b1; cmd.emit_code = stc_pkg::TOK_DIVIDE;
							cmd.emit_last = 1'b1;
							state_d = ST_START;
						end
					end
					stc_pkg::M_COMMENT: begin
						if (st.c == stc_pkg::CH_NEWLINE) begin
							tok_d = stc_pkg::TOK_COMMENT; ident_d = 1'b0;
							after_d = AFT_CLRIDLE; state_d = ST_EMIT;
						end else begin
							cmd.append = 1'b1;
							state_d    = ST_FINAL;
						end
					end
					stc_pkg::M_EQUAL: begin
						if (st.out_free) begin
							cmd.emit = 1'b1; cmd.emit_last = 1'b1;
							if (st.c == stc_pkg::CH_EQUAL) begin
								cmd.emit_code = stc_pkg::TOK_DOUBLEEQUALS;
								cmd.mode_wr = 1'b1;
								state_d = ST_FINAL;
							end else begin
								cmd.emit_code = stc_pkg::TOK_EQUALS;
								state_d = ST_START;
							end
						end
					end
					stc_pkg::M_STRING: begin
						if (st.c == stc_pkg::CH_QUOTE) begin
							tok_d = stc_pkg::TOK_STRING; ident_d = 1'b0;
							after_d = AFT_CLRIDLE; state_d = ST_EMIT;
						end else begin
							cmd.append = 1'b1;
							state_d    = ST_FINAL;
						end
					end
					stc_pkg::M_SKIP: begin
						state_d = ST_FINAL;
					end
					default: begin
						state_d = ST_START;
					end
				endcase
			end
			// open a new token on the current byte
			ST_START: begin
				if (pc[6]) begin
					if (st.out_free) begin
						cmd.clear = 1'b1; cmd.mode_wr = 1'b1;
						cmd.emit = 1'b1; cmd.emit_code = pc[5:0]; cmd.emit_last = 1'b1;
						state_d = ST_FINAL;
					end
				end else begin
					cmd.clear   = 1'b1;
					cmd.mode_wr = 1'b1;
					state_d     = ST_FINAL;
					if (st.c == stc_pkg::CH_SLASH) begin
						cmd.mode_val = stc_pkg::M_SLASH;
					end else if (st.c == stc_pkg::CH_EQUAL) begin
						cmd.mode_val = stc_pkg::M_EQUAL;
					end else if (st.c == stc_pkg::CH_QUOTE) begin
						cmd.mode_val = stc_pkg::M_STRING;
					end else if (dig) begin
						cmd.mode_val = stc_pkg::M_NUMBER;
						cmd.append   = 1'b1;
					end else if (let_c) begin
						cmd.mode_val = stc_pkg::M_IDENT;
						cmd.append   = 1'b1;
					end
				end
			end
			// flush a pending token at end of source, else wait for the next byte
			ST_FINAL: begin
				if (!st.eos) begin
					state_d = ST_WAIT;
				end else begin
					case (st.mode)
						stc_pkg::M_IDENT: begin
							tok_d = stc_pkg::TOK_IDENTIFIER; ident_d = 1'b1;
							after_d = AFT_DONE; state_d = ST_EMIT;
						end
						stc_pkg::M_NUMBER: begin
							tok_d = num_code; ident_d = 1'b0;
							after_d = AFT_DONE; state_d = ST_EMIT;
						end
						stc_pkg::M_COMMENT: begin
							tok_d = stc_pkg::TOK_COMMENT; ident_d = 1'b0;
							after_d = AFT_DONE; state_d = ST_EMIT;
						end
						stc_pkg::M_SLASH, stc_pkg::M_EQUAL, stc_pkg::M_STRING: begin
							if (st.out_free) begin
								cmd.emit = 1'b1; cmd.emit_last = 1'b1;
								cmd.clear = 1'b1; cmd.mode_wr = 1'b1;
								state_d = ST_WAIT;
								if (st.mode == stc_pkg::M_SLASH) begin
									cmd.emit_code = stc_pkg::TOK_DIVIDE;
								end else if (st.mode == stc_pkg::M_EQUAL) begin
									cmd.emit_code = stc_pkg::TOK_EQUALS;
								end else begin
									cmd.emit_code = stc_pkg::TOK_ERROR;
									cmd.emit_err  = stc_pkg::ERR_UNTERM_STR;
								end
							end
						end
						default: begin
							cmd.clear = 1'b1; cmd.mode_wr = 1'b1;
							state_d = ST_WAIT;
						end
					endcase
				end
			end
			// emit a keyword or the buffered content, one result per cycle while the output register is free
			ST_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					if (ident_q && st.kw_hit) begin
						cmd.emit_code = st.kw_code; cmd.emit_last = 1'b1;
						finish = 1'b1;
					end else if (st.len_zero) begin
						cmd.emit_code = tok_q; cmd.emit_last = 1'b1;
						cmd.emit_trunc = st.ovf;
						finish = 1'b1;
					end else begin
						cmd.emit_code = tok_q; cmd.emit_byte = 1'b1;
						cmd.emit_last = st.last_byte; cmd.emit_trunc = st.ovf;
						cmd.idx_inc = 1'b1;
						finish = st.last_byte;
					end
				end
				if (finish) begin
					case (after_q)
						AFT_START: begin
							state_d = ST_START;
						end
						AFT_CLRIDLE: begin
							cmd.clear = 1'b1; cmd.mode_wr = 1'b1;
							state_d = ST_FINAL;
						end
						default: begin
							cmd.clear = 1'b1; cmd.mode_wr = 1'b1;
							state_d = ST_WAIT;
						end
					endcase
				end
			end
			default: begin
				state_d = ST_WAIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WAIT;
			after_q <= AFT_START;
			tok_q   <= stc_pkg::TOK_IDENTIFIER;
			ident_q <= 1'b0;
		end else begin
			state_q <= state_d;
			after_q <= after_d;
			tok_q   <= tok_d;
			ident_q <= ident_d;
		end
	end

endmodule

@@ design/source_code_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// source_code_tokenizer_top: lexical analyzer for a small C-like language
// Source bytes in, token results out, through valid/ready channels.
// ----------------------------------------------------------------------------
// One source byte is taken per transaction on src; results leave on tok.
// A byte that extends a token, closes '==', raises the second decimal point
// error or is skipped after an error passes through take, decode and close.
// A byte seen with no token open also passes through the open step, which
// opens the next token and emits any punctuation. A byte that ends an
// identifier, number, string or comment first emits one result at a time
// (one per buffered content byte, or one for a keyword or empty content),
// then opens a token on that byte unless it was the closing quote or
// newline. A byte that ends a pending '/' or '=' emits in its decode step
// and then goes through the open step. On the end-of-source byte a pending
// identifier, number or comment is emitted result by result; other flushes
// fit in the close step. The single result register paces all emission, so
// downstream stalls add directly. Content longer than MAX_TOKEN_LEN is cut
// and flagged truncated. The next byte is taken only once every result of
// the current one is in the output register.
module source_code_tokenizer_top #(
	parameter int MAX_TOKEN_LEN = stc_pkg::MAX_TOKEN_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	stc_src_if.sink    src,
	stc_tok_if.source  tok
);

	stc_pkg::cmd_t    cmd;
	stc_pkg::status_t st;

	stc_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (src.valid),
		.in_ready (src.ready),
		.st       (st),
		.cmd      (cmd)
	);

	stc_datapath #(
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.char_byte     (src.char_byte),
		.end_of_source (src.end_of_source),
		.tok_ready     (tok.ready),
		.tok_valid     (tok.valid),
		.token_code    (tok.token_code),
		.content_byte  (tok.content_byte),
		.byte_valid    (tok.byte_valid),
		.last_of_token (tok.last_of_token),
		.truncated     (tok.truncated),
		.error_code    (tok.error_code)
	);

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: source code tokenizer testbench
// Drives source bytes through the src channel and checks every token result
// against a behavioral lexer kept in step with each accepted byte.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct packed {
		logic [5:0] code;
		logic [7:0] data;
		logic       bval;
		logic       last;
		logic       trunc;
		logic [1:0] err;
	} token_t;

	localparam int TOKEN_LIMIT  = stc_pkg::MAX_TOKEN_LEN_DEF;
	localparam int CYCLE_LIMIT  = 400000;

	logic clk;
	logic arst_n;
	stc_src_if src ();
	stc_tok_if tok ();

	source_code_tokenizer_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src),
		.tok    (tok)
	);

	// lexer model state
	stc_pkg::mode_t lx_mode;
	logic [7:0]     lx_buf [TOKEN_LIMIT];
	int             lx_len;
	logic           lx_dec;
	logic           lx_ovf;
	token_t         expected_tokens [$];

	int mismatches;
	int results_seen;
	int bytes_sent;
	int cycles;
	int out_wait;

	// clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// abort on runaway
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic digit_c(input logic [7:0] c);
		return c >= 8'd48 && c <= 8'd57;
	endfunction

	function automatic logic letter_c(input logic [7:0] c);
		return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
	endfunction

	function automatic int punct_tok(input logic [7:0] c);
		case (c)
			"+": return stc_pkg::TOK_PLUS;
			"-": return stc_pkg::TOK_MINUS;
			"*": return stc_pkg::TOK_MULTIPLY;
			",": return stc_pkg::TOK_COMMA;
			".": return stc_pkg::TOK_PERIOD;
			"(": return stc_pkg::TOK_LPAREN;
			")": return stc_pkg::TOK_RPAREN;
			"{": return stc_pkg::TOK_LCBRACKET;
			"}": return stc_pkg::TOK_RCBRACKET;
			">": return stc_pkg::TOK_GTHAN;
			"<": return stc_pkg::TOK_LTHAN;
			"[": return stc_pkg::TOK_LHBRACKET;
			"]": return stc_pkg::TOK_RHBRACKET;
			":": return stc_pkg::TOK_COLON;
			";": return stc_pkg::TOK_SEMICOLON;
			default: return -1;
		endcase
	endfunction

	task automatic push_tok(input logic [5:0] code, input logic [7:0] data, input logic bval,
		input logic last, input logic trunc, input logic [1:0] err);
		token_t t;
		t = '{code, data, bval, last, trunc, err};
		expected_tokens.insert(expected_tokens.size(), t);
	endtask

	task automatic clear_content();
		lx_len = 0;
		lx_dec = 1'b0;
		lx_ovf = 1'b0;
	endtask

	task automatic add_byte(input logic [7:0] c);
		if (lx_len < TOKEN_LIMIT) begin
			lx_buf[lx_len] = c;
			lx_len++;
		end else begin
			lx_ovf = 1'b1;
		end
	endtask

	task automatic flush_content(input logic [5:0] code);
		if (lx_len == 0) begin
			push_tok(code, 8'd0, 1'b0, 1'b1, lx_ovf, stc_pkg::ERR_NONE);
		end else begin
			for (int i = 0; i < lx_len; i++)
				push_tok(code, lx_buf[i], 1'b1, i == lx_len - 1, lx_ovf, stc_pkg::ERR_NONE);
		end
	endtask

	// keyword lookup, else identifier content
	task automatic flush_word();
		string words [10];
		int    codes [10];
		logic  hit;
		words = '{"if", "else", "int", "float", "struct", "return", "void", "true", "false",
			"bool"};
		codes = '{1, 2, 3, 5, 4, 26, 27, 31, 32, 30};
		if (!lx_ovf) begin
			for (int k = 0; k < 10; k++) begin
				if (words[k].len() == lx_len) begin
					hit = 1'b1;
					for (int i = 0; i < lx_len; i++)
						if (words[k][i] != lx_buf[i]) hit = 1'b0;
					if (hit) begin
						push_tok(6'(codes[k]), 8'd0, 1'b0, 1'b1, 1'b0, stc_pkg::ERR_NONE);
						return;
					end
				end
			end
		end
		flush_content(stc_pkg::TOK_IDENTIFIER);
	endtask

	task automatic open_token(input logic [7:0] c);
		int p;
		p = punct_tok(c);
		lx_mode = stc_pkg::M_IDLE;
		clear_content();
		if (p >= 0) push_tok(6'(p), 8'd0, 1'b0, 1'b1, 1'b0, stc_pkg::ERR_NONE);
		else if (c == stc_pkg::CH_SLASH) lx_mode = stc_pkg::M_SLASH;
		else if (c == stc_pkg::CH_EQUAL) lx_mode = stc_pkg::M_EQUAL;
		else if (c == stc_pkg::CH_QUOTE) lx_mode = stc_pkg::M_STRING;
		else if (digit_c(c)) begin
			lx_mode = stc_pkg::M_NUMBER;
			add_byte(c);
		end else if (letter_c(c)) begin
			lx_mode = stc_pkg::M_IDENT;
			add_byte(c);
		end
	endtask

	// advance the lexer model by one accepted byte
	task automatic lex_byte(input logic [7:0] c, input logic eos);
		case (lx_mode)
			stc_pkg::M_IDENT: begin
				if (digit_c(c) || letter_c(c)) add_byte(c);
				else begin
					flush_word();
					open_token(c);
				end
			end
			stc_pkg::M_NUMBER: begin
				if (digit_c(c)) add_byte(c);
				else if (c == stc_pkg::CH_DOT) begin
					if (lx_dec) begin
						push_tok(stc_pkg::TOK_ERROR, 8'd0, 1'b0, 1'b1, 1'b0,
							stc_pkg::ERR_DECIMAL);
						clear_content();
						lx_mode = stc_pkg::M_SKIP;
					end else begin
						lx_dec = 1'b1;
						add_byte(c);
					end
				end else begin
					flush_content(lx_dec ? stc_pkg::TOK_FLOAT_DATA : stc_pkg::TOK_INT_DATA);
					open_token(c);
				end
			end
			stc_pkg::M_SLASH: begin
				if (c == stc_pkg::CH_SLASH) begin
					clear_content();
					lx_mode = stc_pkg::M_COMMENT;
				end else begin
					push_tok(stc_pkg::TOK_DIVIDE, 8'd0, 1'b0, 1'b1, 1'b0, stc_pkg::ERR_NONE);
					open_token(c);
				end
			end
			stc_pkg::M_COMMENT: begin
				if (c == stc_pkg::CH_NEWLINE) begin
					flush_content(stc_pkg::TOK_COMMENT);
					clear_content();
					lx_mode = stc_pkg::M_IDLE;
				end else add_byte(c);
			end
			stc_pkg::M_EQUAL: begin
				if (c == stc_pkg::CH_EQUAL) begin
					push_tok(stc_pkg::TOK_DOUBLEEQUALS, 8'd0, 1'b0, 1'b1, 1'b0,
						stc_pkg::ERR_NONE);
					lx_mode = stc_pkg::M_IDLE;
				end else begin
					push_tok(stc_pkg::TOK_EQUALS, 8'd0, 1'b0, 1'b1, 1'b0, stc_pkg::ERR_NONE);
					open_token(c);
				end
			end
			stc_pkg::M_STRING: begin
				if (c == stc_pkg::CH_QUOTE) begin
					flush_content(stc_pkg::TOK_STRING);
					clear_content();
					lx_mode = stc_pkg::M_IDLE;
				end else add_byte(c);
			end
			stc_pkg::M_SKIP: ;
			default: open_token(c);
		endcase
		if (eos) begin
			case (lx_mode)
				stc_pkg::M_IDENT: flush_word();
				stc_pkg::M_NUMBER:
					flush_content(lx_dec ? stc_pkg::TOK_FLOAT_DATA : stc_pkg::TOK_INT_DATA);
				stc_pkg::M_SLASH:
					push_tok(stc_pkg::TOK_DIVIDE, 8'd0, 1'b0, 1'b1, 1'b0, stc_pkg::ERR_NONE);
				stc_pkg::M_COMMENT: flush_content(stc_pkg::TOK_COMMENT);
				stc_pkg::M_EQUAL:
					push_tok(stc_pkg::TOK_EQUALS, 8'd0, 1'b0, 1'b1, 1'b0, stc_pkg::ERR_NONE);
				stc_pkg::M_STRING:
					push_tok(stc_pkg::TOK_ERROR, 8'd0, 1'b0, 1'b1, 1'b0,
						stc_pkg::ERR_UNTERM_STR);
				default: ;
			endcase
			lx_mode = stc_pkg::M_IDLE;
			clear_content();
		end
	endtask

	// send one byte; the model steps at acceptance
	task automatic send_byte(input logic [7:0] c, input logic eos);
		int gap;
		gap = $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			src.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src.valid         <= 1'b1;
		src.char_byte     <= c;
		src.end_of_source <= eos;
		@(posedge clk);
		while (!src.ready) @(posedge clk);
		lex_byte(c, eos);
		bytes_sent++;
	endtask

	task automatic send_text(input string s, input logic eos_at_end);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], eos_at_end && i == s.len() - 1);
	endtask

	// hold the token side off for a drawn number of cycles after each transaction
	always @(posedge clk) begin
		int w;
		if (!arst_n) begin
			tok.ready <= 1'b0;
			out_wait  <= 0;
		end else if (tok.valid && tok.ready) begin
			w = $urandom_range(0, 3);
			out_wait  <= w;
			tok.ready <= (w == 0);
		end else if (out_wait > 0) begin
			out_wait  <= out_wait - 1;
			tok.ready <= (out_wait == 1);
		end else begin
			tok.ready <= 1'b1;
		end
	end

	// compare each accepted token result with the oldest expectation
	always @(posedge clk) begin
		token_t got, want;
		if (arst_n && tok.valid && tok.ready) begin
			got = '{tok.token_code, tok.content_byte, tok.byte_valid, tok.last_of_token,
				tok.truncated, tok.error_code};
			results_seen++;
			if (expected_tokens.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected token result %h", got);
			end else begin
				want = expected_tokens.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp code=%0d byte=%h v=%b l=%b t=%b e=%0d,",
							" got code=%0d byte=%h v=%b l=%b t=%b e=%0d"},
							want.code, want.data, want.bval, want.last, want.trunc, want.err,
							got.code, got.data, got.bval, got.last, got.trunc, got.err);
				end
			end
		end
	end

	task automatic test_punctuation();
		send_text("+-*,.(){}<>[]:;", 1'b0);
		send_text("= == / x", 1'b0);
		send_text("=", 1'b1);
	endtask

	task automatic test_keywords();
		send_text("if else int float struct return void true false bool iff", 1'b1);
	endtask

	task automatic test_special_cases();
		send_text("12.5.7 junk\"abc", 1'b1);
		send_text("\"hello\" \"\" // note\n//", 1'b1);
		send_text("\"open", 1'b1);
		send_text("3.25 42", 1'b1);
		send_text("abcdefghijklmnopqrstuvwxyzABCDEFGHIJ ", 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h00, 1'b1);
	endtask

	function automatic logic [7:0] rand_letter();
		return $urandom_range(0, 1) ? 8'($urandom_range(97, 122)) : 8'($urandom_range(65, 90));
	endfunction

	// random programs built mostly from well-formed tokens
	task automatic test_random_source();
		string kws [10];
		string puncts;
		int    kind;
		int    n;
		kws = '{"if", "else", "int", "float", "struct", "return", "void", "true", "false", "bool"};
		puncts = "+-*,.(){}<>[]:;";
		while (bytes_sent < 440) begin
			kind = $urandom_range(0, 11);
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 6);
			case (kind)
				0: send_text(kws[$urandom_range(0, 9)], 1'b0);
				1: begin
					send_byte(rand_letter(), 1'b0);
					repeat (n) send_byte($urandom_range(0, 1) ? rand_letter()
						: 8'($urandom_range(48, 57)), 1'b0);
				end
				2: begin
					repeat (n + 1) send_byte(8'($urandom_range(48, 57)), 1'b0);
					if ($urandom_range(0, 1)) send_byte(stc_pkg::CH_DOT, 1'b0);
					repeat (n % 3) send_byte(8'($urandom_range(48, 57)), 1'b0);
					if ($urandom_range(0, 7) == 0) send_byte(stc_pkg::CH_DOT, 1'b0);
				end
				3: begin
					send_byte(stc_pkg::CH_QUOTE, 1'b0);
					repeat (n) send_byte(8'($urandom_range(32, 126)) == stc_pkg::CH_QUOTE
						? 8'h41 : 8'($urandom_range(32, 126)), 1'b0);
					if ($urandom_range(0, 7) != 0) send_byte(stc_pkg::CH_QUOTE, 1'b0);
				end
				4: begin
					send_text("//", 1'b0);
					repeat (n) send_byte(8'($urandom_range(11, 255)), 1'b0);
					send_byte(stc_pkg::CH_NEWLINE, 1'b0);
				end
				5: send_text($urandom_range(0, 1) ? "==" : "=", 1'b0);
				6: send_byte(stc_pkg::CH_SLASH, 1'b0);
				7: send_byte(puncts[$urandom_range(0, 14)], 1'b0);
				8: send_byte(8'($urandom_range(0, 255)), 1'b0);
				9: send_byte(" ", 1'b0);
				10: send_byte(stc_pkg::CH_NEWLINE, 1'b0);
				default: send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
			endcase
			if ($urandom_range(0, 2) == 0) send_byte(" ", 1'b0);
			if ($urandom_range(0, 15) == 0) send_byte(8'($urandom_range(0, 255)), 1'b1);
		end
		send_byte(" ", 1'b1);
	endtask

	initial begin
		arst_n            = 1'b0;
		cycles            = 0;
		mismatches        = 0;
		results_seen      = 0;
		bytes_sent        = 0;
		src.valid         = 1'b0;
		src.char_byte     = 8'd0;
		src.end_of_source = 1'b0;
		tok.ready         = 1'b0;
		lx_mode           = stc_pkg::M_IDLE;
		clear_content();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_punctuation();
		test_keywords();
		test_special_cases();
		test_random_source();
		src.valid <= 1'b0;

		// drain, then allow trailing cycles
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("covered %0d source bytes and %0d token results", bytes_sent, results_seen);
		$display("mismatches: %0d", mismatches);
		if (mismatches == 0 && expected_tokens.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
design/stc_pkg.sv
design/stc_src_if.sv
design/stc_tok_if.sv
design/stc_datapath.sv
design/stc_controller.sv
design/source_code_tokenizer_top.sv
tb/tb_top.sv
